// File: rtl/core/sst_pkg.sv
// Shared types and constants for the scoped symbol table.
// Holds operation and status codes, stream field layout and parameter defaults.
// No dependencies.
package sst_pkg;

  // Parameter defaults
  localparam int unsigned DEF_ENTRIES   = 64;
  localparam int unsigned DEF_LEVELS    = 16;
  localparam int unsigned DEF_KEY_BITS  = 64;
  localparam int unsigned DEF_KIND_BITS = 4;

  // Input item field widths and positions (lowest bit first)
  localparam int unsigned FUNC_W     = 2;
  localparam int unsigned KEY_W      = 64;
  localparam int unsigned KIND_W     = 4;
  localparam int unsigned FUNC_LSB   = 0;
  localparam int unsigned KEY_LSB    = FUNC_LSB + FUNC_W;
  localparam int unsigned KIND_LSB   = KEY_LSB + KEY_W;
  localparam int unsigned IN_BITS    = KIND_LSB + KIND_W;
  localparam int unsigned IN_TDATA_W = ((IN_BITS + 7) / 8) * 8;

  // Result item field widths and positions (lowest bit first)
  localparam int unsigned STATUS_W    = 3;
  localparam int unsigned FLEVEL_W    = 4;
  localparam int unsigned NUM_W       = 6;
  localparam int unsigned CUR_W       = 5;
  localparam int unsigned OUT_BITS    = STATUS_W + FLEVEL_W + NUM_W + CUR_W;
  localparam int unsigned OUT_TDATA_W = ((OUT_BITS + 7) / 8) * 8;

  typedef enum logic [FUNC_W-1:0] {
    FN_OPEN   = 2'd0,
    FN_CLOSE  = 2'd1,
    FN_INSERT = 2'd2,
    FN_LOOKUP = 2'd3
  } func_e;

  typedef enum logic [STATUS_W-1:0] {
    ST_DONE       = 3'd0,
    ST_FOUND      = 3'd1,
    ST_WRONG_TYPE = 3'd2,
    ST_NOT_FOUND  = 3'd3,
    ST_DUPLICATE  = 3'd4,
    ST_FULL       = 3'd5,
    ST_TOO_DEEP   = 3'd6,
    ST_NO_SCOPE   = 3'd7
  } status_e;

  // One result item as handed from the sequencer to the output register
  typedef struct packed {
    logic [CUR_W-1:0]    current_level;
    logic [NUM_W-1:0]    entry_number;
    logic [FLEVEL_W-1:0] found_level;
    status_e             status;
  } result_t;

endpackage

// File: rtl/core/sst_entry_store.sv
// Entry memory of the scoped symbol table: key, kind and level per slot.
// One write port, one registered read port. Depends on sst_pkg for parameter defaults.
module sst_entry_store
  import sst_pkg::*;
#(
  parameter int unsigned ENTRIES   = DEF_ENTRIES,
  parameter int unsigned LEVELS    = DEF_LEVELS,
  parameter int unsigned KEY_BITS  = DEF_KEY_BITS,
  parameter int unsigned KIND_BITS = DEF_KIND_BITS,
  localparam int unsigned IDX_W    = $clog2(ENTRIES),
  localparam int unsigned LVL_W    = $clog2(LEVELS)
) (
  input  logic                 clk_i,
  input  logic                 we_i,
  input  logic [IDX_W-1:0]     waddr_i,
  input  logic [KEY_BITS-1:0]  wkey_i,
  input  logic [KIND_BITS-1:0] wkind_i,
  input  logic [LVL_W-1:0]     wlevel_i,
  input  logic                 re_i,
  input  logic [IDX_W-1:0]     raddr_i,
  output logic [KEY_BITS-1:0]  rkey_o,
  output logic [KIND_BITS-1:0] rkind_o,
  output logic [LVL_W-1:0]     rlevel_o
);

  localparam int unsigned WORD_W = KEY_BITS + KIND_BITS + LVL_W;

  logic [WORD_W-1:0] mem [ENTRIES];
  logic [WORD_W-1:0] rdata_q;

  // Write one slot
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= {wlevel_i, wkind_i, wkey_i};
    end
  end

  // Registered read
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rkey_o   = rdata_q[KEY_BITS-1:0];
  assign rkind_o  = rdata_q[KEY_BITS +: KIND_BITS];
  assign rlevel_o = rdata_q[KEY_BITS+KIND_BITS +: LVL_W];

endmodule

// File: rtl/core/sst_base_store.sv
// Level base memory: stack top recorded when each scope level opened.
// One write port, one registered read port. Depends on sst_pkg for parameter defaults.
module sst_base_store
  import sst_pkg::*;
#(
  parameter int unsigned ENTRIES = DEF_ENTRIES,
  parameter int unsigned LEVELS  = DEF_LEVELS,
  localparam int unsigned CNT_W  = $clog2(ENTRIES + 1),
  localparam int unsigned LVL_W  = $clog2(LEVELS)
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [LVL_W-1:0] waddr_i,
  input  logic [CNT_W-1:0] wdata_i,
  input  logic             re_i,
  input  logic [LVL_W-1:0] raddr_i,
  output logic [CNT_W-1:0] rdata_o
);

  logic [CNT_W-1:0] mem [LEVELS];

  // Record a base
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  // Registered read
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_o <= mem[raddr_i];
    end
  end

endmodule

// File: rtl/core/sst_seq.sv
// Sequencer of the scoped symbol table: scope state, entry scan and key compare.
// Depends on sst_pkg; drives sst_entry_store and sst_base_store.
module sst_seq
  import sst_pkg::*;
#(
  parameter int unsigned ENTRIES   = DEF_ENTRIES,
  parameter int unsigned LEVELS    = DEF_LEVELS,
  parameter int unsigned KEY_BITS  = DEF_KEY_BITS,
  parameter int unsigned KIND_BITS = DEF_KIND_BITS,
  localparam int unsigned IDX_W    = $clog2(ENTRIES),
  localparam int unsigned CNT_W    = $clog2(ENTRIES + 1),
  localparam int unsigned LVL_W    = $clog2(LEVELS),
  localparam int unsigned OL_W     = LVL_W + 1
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  // input item
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  input  func_e                func_i,
  input  logic [KEY_BITS-1:0]  key_i,
  input  logic [KIND_BITS-1:0] kind_i,
  // result item
  output logic                 res_valid_o,
  input  logic                 res_take_i,
  output result_t              res_o,
  // entry memory
  output logic                 ent_we_o,
  output logic [IDX_W-1:0]     ent_waddr_o,
  output logic [KEY_BITS-1:0]  ent_wkey_o,
  output logic [KIND_BITS-1:0] ent_wkind_o,
  output logic [LVL_W-1:0]     ent_wlevel_o,
  output logic                 ent_re_o,
  output logic [IDX_W-1:0]     ent_raddr_o,
  input  logic [KEY_BITS-1:0]  ent_rkey_i,
  input  logic [KIND_BITS-1:0] ent_rkind_i,
  input  logic [LVL_W-1:0]     ent_rlevel_i,
  // level base memory
  output logic                 base_we_o,
  output logic [LVL_W-1:0]     base_waddr_o,
  output logic [CNT_W-1:0]     base_wdata_o,
  output logic                 base_re_o,
  output logic [LVL_W-1:0]     base_raddr_o,
  input  logic [CNT_W-1:0]     base_rdata_i
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_EXEC,
    S_BASE,
    S_SCAN,
    S_LKBASE,
    S_RESP
  } state_e;

  state_e                 state_q, state_d;
  func_e                  func_q, func_d;
  logic [KEY_BITS-1:0]    key_q, key_d;
  logic [KIND_BITS-1:0]   kind_q, kind_d;
  logic signed [OL_W-1:0] open_q, open_d;
  logic [CNT_W-1:0]       top_q, top_d;
  logic [CNT_W-1:0]       base_q, base_d;
  logic [CNT_W-1:0]       ptr_q, ptr_d;
  logic                   pend_q, pend_d;
  logic [IDX_W-1:0]       pidx_q, pidx_d;
  logic [LVL_W-1:0]       lv_q, lv_d;
  status_e                st_q, st_d;
  logic [FLEVEL_W-1:0]    flv_q, flv_d;
  logic [NUM_W-1:0]       num_q, num_d;

  logic                   no_scope;
  logic                   too_deep;
  logic                   key_hit;
  logic [CNT_W-1:0]       ptr_dec;
  logic [CNT_W-1:0]       lk_num;
  logic [CNT_W-1:0]       ins_num;

  assign no_scope = open_q[OL_W-1];
  assign too_deep = (open_q == OL_W'(LEVELS - 1));
  assign key_hit  = pend_q && (ent_rkey_i == key_q);
  assign ptr_dec  = ptr_q - CNT_W'(1);
  assign lk_num   = CNT_W'(pidx_q) - base_rdata_i;
  assign ins_num  = top_q - base_q;

  assign in_ready_o  = (state_q == S_IDLE);
  assign res_valid_o = (state_q == S_RESP);

  // Current level is taken from the scope state once the step has settled
  always_comb begin
    res_o.status        = st_q;
    res_o.found_level   = flv_q;
    res_o.entry_number  = num_q;
    res_o.current_level = CUR_W'(open_q);
  end

  // Next state and memory control
  always_comb begin
    state_d = state_q;
    func_d  = func_q;
    key_d   = key_q;
    kind_d  = kind_q;
    open_d  = open_q;
    top_d   = top_q;
    base_d  = base_q;
    ptr_d   = ptr_q;
    pend_d  = 1'b0;
    pidx_d  = pidx_q;
    lv_d    = lv_q;
    st_d    = st_q;
    flv_d   = flv_q;
    num_d   = num_q;

    ent_we_o     = 1'b0;
    ent_waddr_o  = top_q[IDX_W-1:0];
    ent_wkey_o   = key_q;
    ent_wkind_o  = kind_q;
    ent_wlevel_o = open_q[LVL_W-1:0];
    ent_re_o     = 1'b0;
    ent_raddr_o  = ptr_q[IDX_W-1:0];
    base_we_o    = 1'b0;
    base_waddr_o = LVL_W'(open_q + OL_W'(1));
    base_wdata_o = top_q;
    base_re_o    = 1'b0;
    base_raddr_o = open_q[LVL_W-1:0];

    case (state_q)
      S_IDLE: begin
        // Latch the item
        if (in_valid_i) begin
          func_d  = func_i;
          key_d   = key_i;
          kind_d  = kind_i;
          st_d    = ST_DONE;
          flv_d   = '0;
          num_d   = '0;
          state_d = S_EXEC;
        end
      end
      S_EXEC: begin
        case (func_q)
          FN_OPEN: begin
            // Push a level and record the current stack top as its base
            if (too_deep) begin
              st_d = ST_TOO_DEEP;
            end else begin
              base_we_o = 1'b1;
              open_d    = open_q + OL_W'(1);
            end
            state_d = S_RESP;
          end
          FN_CLOSE, FN_INSERT: begin
            if (no_scope) begin
              st_d    = ST_NO_SCOPE;
              state_d = S_RESP;
            end else begin
              base_re_o = 1'b1;
              state_d   = S_BASE;
            end
          end
          FN_LOOKUP: begin
            // Scan from the newest entry down
            ptr_d   = top_q;
            state_d = S_SCAN;
          end
          default: state_d = S_RESP;
        endcase
      end
      S_BASE: begin
        if (func_q == FN_CLOSE) begin
          // Cut the stack back to the level's base and pop
          top_d   = base_rdata_i;
          open_d  = open_q - OL_W'(1);
          state_d = S_RESP;
        end else begin
          base_d  = base_rdata_i;
          ptr_d   = base_rdata_i;
          state_d = S_SCAN;
        end
      end
      S_SCAN: begin
        if (func_q == FN_INSERT) begin
          // Scan the innermost level upward for a duplicate
          if (key_hit) begin
            st_d    = ST_DUPLICATE;
            state_d = S_RESP;
          end else if (ptr_q < top_q) begin
            ent_re_o    = 1'b1;
            ent_raddr_o = ptr_q[IDX_W-1:0];
            ptr_d       = ptr_q + CNT_W'(1);
            pend_d      = 1'b1;
            pidx_d      = ptr_q[IDX_W-1:0];
          end else if (!pend_q) begin
            if (top_q >= CNT_W'(ENTRIES)) begin
              st_d = ST_FULL;
            end else begin
              ent_we_o = 1'b1;
              top_d    = top_q + CNT_W'(1);
              num_d    = NUM_W'(ins_num);
            end
            state_d = S_RESP;
          end
        end else begin
          // Lookup: the first hit is the innermost binding
          if (key_hit) begin
            if (ent_rkind_i != kind_q) begin
              st_d    = ST_WRONG_TYPE;
              state_d = S_RESP;
            end else begin
              base_re_o    = 1'b1;
              base_raddr_o = ent_rlevel_i;
              lv_d         = ent_rlevel_i;
              state_d      = S_LKBASE;
            end
          end else if (ptr_q != '0) begin
            ent_re_o    = 1'b1;
            ent_raddr_o = ptr_dec[IDX_W-1:0];
            ptr_d       = ptr_dec;
            pend_d      = 1'b1;
            pidx_d      = ptr_dec[IDX_W-1:0];
          end else if (!pend_q) begin
            st_d    = ST_NOT_FOUND;
            state_d = S_RESP;
          end
        end
      end
      S_LKBASE: begin
        st_d    = ST_FOUND;
        flv_d   = FLEVEL_W'(lv_q);
        num_d   = NUM_W'(lk_num);
        state_d = S_RESP;
      end
      S_RESP: begin
        // Hold the result until the output register takes it
        if (res_take_i) begin
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  // State and registered values
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      open_q  <= '1;
      top_q   <= '0;
      pend_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      open_q  <= open_d;
      top_q   <= top_d;
      pend_q  <= pend_d;
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    func_q <= func_d;
    key_q  <= key_d;
    kind_q <= kind_d;
    base_q <= base_d;
    ptr_q  <= ptr_d;
    pidx_q <= pidx_d;
    lv_q   <= lv_d;
    st_q   <= st_d;
    flv_q  <= flv_d;
    num_q  <= num_d;
  end

endmodule

// File: rtl/core/scoped_symbol_table.sv
// Top level of the scoped symbol table: stream ports, output register, stores.
// Depends on sst_pkg, sst_seq, sst_entry_store and sst_base_store.
//
//   channel   dir  handshake                    payload
//   s_axis    in   s_axis_tvalid/s_axis_tready  s_axis_tdata: func, key, kind
//   m_axis    out  m_axis_tvalid/m_axis_tready  m_axis_tdata: status, found_level,
//                                               entry_number, current_level
//
// Insert compares the key with each entry at the innermost level; lookup
// compares it with the entries from the newest down to the first hit. The
// single read port of the entry RAM limits both scans: one stored key is
// compared per cycle.
// Reset empties the table and closes all scopes; no clearing pass is run.
// The next item is taken while a result still waits in the output register.
module scoped_symbol_table
  import sst_pkg::*;
#(
  parameter int unsigned ENTRIES   = DEF_ENTRIES,
  parameter int unsigned LEVELS    = DEF_LEVELS,
  parameter int unsigned KEY_BITS  = DEF_KEY_BITS,
  parameter int unsigned KIND_BITS = DEF_KIND_BITS
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   s_axis_tvalid,
  output logic                   s_axis_tready,
  // func [1:0], key [65:2], kind [69:66], zero [71:70]
  input  logic [IN_TDATA_W-1:0]  s_axis_tdata,
  output logic                   m_axis_tvalid,
  input  logic                   m_axis_tready,
  // status [2:0], found_level [6:3], entry_number [12:7], current_level [17:13],
  // zero [23:18]
  output logic [OUT_TDATA_W-1:0] m_axis_tdata
);

  localparam int unsigned IDX_W = $clog2(ENTRIES);
  localparam int unsigned CNT_W = $clog2(ENTRIES + 1);
  localparam int unsigned LVL_W = $clog2(LEVELS);

  logic [FUNC_W-1:0]    in_func;
  logic [KEY_W-1:0]     in_key;
  logic [KIND_W-1:0]    in_kind;

  logic                 res_valid;
  logic                 res_take;
  result_t              res;
  logic                 m_valid_q;
  result_t              m_res_q;

  logic                 ent_we;
  logic [IDX_W-1:0]     ent_waddr;
  logic [KEY_BITS-1:0]  ent_wkey;
  logic [KIND_BITS-1:0] ent_wkind;
  logic [LVL_W-1:0]     ent_wlevel;
  logic                 ent_re;
  logic [IDX_W-1:0]     ent_raddr;
  logic [KEY_BITS-1:0]  ent_rkey;
  logic [KIND_BITS-1:0] ent_rkind;
  logic [LVL_W-1:0]     ent_rlevel;

  logic                 base_we;
  logic [LVL_W-1:0]     base_waddr;
  logic [CNT_W-1:0]     base_wdata;
  logic                 base_re;
  logic [LVL_W-1:0]     base_raddr;
  logic [CNT_W-1:0]     base_rdata;

  // Unpack the input item
  assign in_func = s_axis_tdata[FUNC_LSB +: FUNC_W];
  assign in_key  = s_axis_tdata[KEY_LSB +: KEY_W];
  assign in_kind = s_axis_tdata[KIND_LSB +: KIND_W];

  sst_seq #(
    .ENTRIES   (ENTRIES),
    .LEVELS    (LEVELS),
    .KEY_BITS  (KEY_BITS),
    .KIND_BITS (KIND_BITS)
  ) u_seq (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (s_axis_tvalid),
    .in_ready_o   (s_axis_tready),
    .func_i       (func_e'(in_func)),
    .key_i        (in_key[KEY_BITS-1:0]),
    .kind_i       (in_kind[KIND_BITS-1:0]),
    .res_valid_o  (res_valid),
    .res_take_i   (res_take),
    .res_o        (res),
    .ent_we_o     (ent_we),
    .ent_waddr_o  (ent_waddr),
    .ent_wkey_o   (ent_wkey),
    .ent_wkind_o  (ent_wkind),
    .ent_wlevel_o (ent_wlevel),
    .ent_re_o     (ent_re),
    .ent_raddr_o  (ent_raddr),
    .ent_rkey_i   (ent_rkey),
    .ent_rkind_i  (ent_rkind),
    .ent_rlevel_i (ent_rlevel),
    .base_we_o    (base_we),
    .base_waddr_o (base_waddr),
    .base_wdata_o (base_wdata),
    .base_re_o    (base_re),
    .base_raddr_o (base_raddr),
    .base_rdata_i (base_rdata)
  );

  sst_entry_store #(
    .ENTRIES   (ENTRIES),
    .LEVELS    (LEVELS),
    .KEY_BITS  (KEY_BITS),
    .KIND_BITS (KIND_BITS)
  ) u_entries (
    .clk_i    (clk_i),
    .we_i     (ent_we),
    .waddr_i  (ent_waddr),
    .wkey_i   (ent_wkey),
    .wkind_i  (ent_wkind),
    .wlevel_i (ent_wlevel),
    .re_i     (ent_re),
    .raddr_i  (ent_raddr),
    .rkey_o   (ent_rkey),
    .rkind_o  (ent_rkind),
    .rlevel_o (ent_rlevel)
  );

  sst_base_store #(
    .ENTRIES (ENTRIES),
    .LEVELS  (LEVELS)
  ) u_bases (
    .clk_i   (clk_i),
    .we_i    (base_we),
    .waddr_i (base_waddr),
    .wdata_i (base_wdata),
    .re_i    (base_re),
    .raddr_i (base_raddr),
    .rdata_o (base_rdata)
  );

  // Output register: load when empty or being drained
  assign res_take = res_valid && (!m_valid_q || m_axis_tready);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_valid_q <= 1'b0;
    end else if (res_take) begin
      m_valid_q <= 1'b1;
    end else if (m_axis_tready) begin
      m_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_take) begin
      m_res_q <= res;
    end
  end

  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata  = OUT_TDATA_W'(m_res_q);

endmodule

// File: rtl/core/sst_checker.sv
// Port-level checks for the scoped symbol table, bound to the top level.
// Depends on sst_pkg and scoped_symbol_table.
module sst_checker
  import sst_pkg::*;
(
  input logic                   clk_i,
  input logic                   rst_ni,
  input logic                   s_axis_tvalid,
  input logic                   s_axis_tready,
  input logic                   m_axis_tvalid,
  input logic                   m_axis_tready,
  input logic [OUT_TDATA_W-1:0] m_axis_tdata
);

  logic [STATUS_W-1:0] out_status;
  logic [FLEVEL_W-1:0] out_flevel;
  logic [CUR_W-1:0]    out_cur;

  assign out_status = m_axis_tdata[STATUS_W-1:0];
  assign out_flevel = m_axis_tdata[STATUS_W +: FLEVEL_W];
  assign out_cur    = m_axis_tdata[STATUS_W+FLEVEL_W+NUM_W +: CUR_W];

  // A stalled result holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("stalled result changed");

  // One item at a time: busy right after an accept
  a_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
    else $error("item accepted while busy");

  // Found level is zero unless the key was found
  a_flevel: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && (out_status != ST_FOUND) |-> out_flevel == '0)
    else $error("found level set without a hit");

  // No open scope leaves the level at minus one
  a_noscope: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && (out_status == ST_NO_SCOPE) |-> out_cur == '1)
    else $error("no-scope result with a scope open");

endmodule

bind scoped_symbol_table sst_checker u_sst_checker (.*);

// File: tb/sv/tb_top.sv
// Self-checking testbench for the scoped symbol table stream block.
// Depends on sst_pkg and scoped_symbol_table; a built-in predictor checks every result item.
`timescale 1ns / 1ps

module tb_top;
  import sst_pkg::*;

  localparam int unsigned ENTRIES      = DEF_ENTRIES;
  localparam int unsigned LEVELS       = DEF_LEVELS;
  localparam int unsigned POOL_SIZE    = 24;
  localparam int unsigned DRAIN_CYCLES = 100;
  localparam int unsigned LIMIT_CYCLES = 1000000;

  logic                   clk_i;
  logic                   rst_ni;
  logic                   s_axis_tvalid = 1'b0;
  logic                   s_axis_tready;
  // func [1:0], key [65:2], kind [69:66], zero [71:70]
  logic [IN_TDATA_W-1:0]  s_axis_tdata = '0;
  logic                   m_axis_tvalid;
  logic                   m_axis_tready = 1'b0;
  // status [2:0], found_level [6:3], entry_number [12:7], current_level [17:13],
  // zero [23:18]
  logic [OUT_TDATA_W-1:0] m_axis_tdata;

  scoped_symbol_table u_dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata)
  );

  // Shadow copy of the symbol stack and scope bases
  logic [KEY_W-1:0]    sym_key   [ENTRIES];
  logic [KIND_W-1:0]   sym_kind  [ENTRIES];
  logic [FLEVEL_W-1:0] sym_level [ENTRIES];
  int                  scope_base[LEVELS];
  int                  stack_top;
  int                  cur_scope;

  // Result items still owed by the block, oldest first
  result_t             pending_results[$];

  // Key pool for random traffic, so lookups hit and duplicates occur
  logic [KEY_W-1:0]    key_pool [POOL_SIZE];
  logic [KIND_W-1:0]   kind_pool[POOL_SIZE];

  int unsigned src_idle_pct  = 17;
  int unsigned sink_idle_pct = 51;
  int unsigned error_count   = 0;
  int unsigned items_sent    = 0;
  int unsigned results_seen  = 0;
  int unsigned deepest_scope = 0;
  int unsigned status_count[8];
  int unsigned cycle_count   = 0;

  // Clock
  initial begin
    clk_i = 1'b0;
    forever #6 clk_i = ~clk_i;
  end

  // Watchdog
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= LIMIT_CYCLES) begin
      $display("%0t: timeout with %0d result items outstanding", $time,
               pending_results.size());
      $display("[scoped_symbol_table] ERROR");
      $finish;
    end
  end

  // Receiver back-pressure
  always @(negedge clk_i) begin
    m_axis_tready <= ($urandom_range(99) >= sink_idle_pct);
  end

  // Compute the result of one operation and advance the shadow table
  function automatic result_t predict_result(func_e fn, logic [KEY_W-1:0] key,
                                             logic [KIND_W-1:0] kind);
    result_t r;
    int      base;
    int      e;
    int      num;
    bit      hit;
    r        = '0;
    r.status = ST_DONE;
    hit      = 1'b0;
    case (fn)
      FN_OPEN: begin
        if (cur_scope >= int'(LEVELS) - 1) begin
          r.status = ST_TOO_DEEP;
        end else begin
          cur_scope++;
          scope_base[cur_scope] = stack_top;
        end
      end
      FN_CLOSE: begin
        if (cur_scope < 0) begin
          r.status = ST_NO_SCOPE;
        end else begin
          stack_top = scope_base[cur_scope];
          cur_scope--;
        end
      end
      FN_INSERT: begin
        if (cur_scope < 0) begin
          r.status = ST_NO_SCOPE;
        end else begin
          base = scope_base[cur_scope];
          for (e = base; e < stack_top; e++) begin
            if (sym_key[e] == key) hit = 1'b1;
          end
          if (hit) begin
            r.status = ST_DUPLICATE;
          end else if (stack_top >= int'(ENTRIES)) begin
            r.status = ST_FULL;
          end else begin
            sym_key[stack_top]   = key;
            sym_kind[stack_top]  = kind;
            sym_level[stack_top] = cur_scope[FLEVEL_W-1:0];
            num                  = stack_top - base;
            r.entry_number       = num[NUM_W-1:0];
            stack_top++;
          end
        end
      end
      default: begin
        // Search newest to oldest; the innermost binding decides
        r.status = ST_NOT_FOUND;
        for (e = stack_top - 1; e >= 0; e--) begin
          if (!hit && sym_key[e] == key) begin
            hit = 1'b1;
            if (sym_kind[e] != kind) begin
              r.status = ST_WRONG_TYPE;
            end else begin
              r.status       = ST_FOUND;
              r.found_level  = sym_level[e];
              num            = e - scope_base[sym_level[e]];
              r.entry_number = num[NUM_W-1:0];
            end
          end
        end
      end
    endcase
    r.current_level = cur_scope[CUR_W-1:0];
    return r;
  endfunction

  // Send one item; called and returns at a falling edge
  task automatic send_item(func_e fn, logic [KEY_W-1:0] key, logic [KIND_W-1:0] kind);
    result_t r;
    r = predict_result(fn, key, kind);
    pending_results = {pending_results, r};
    status_count[r.status]++;
    if (cur_scope > int'(deepest_scope)) deepest_scope = cur_scope;
    while ($urandom_range(99) < src_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(negedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {{(IN_TDATA_W - IN_BITS){1'b0}}, kind, key, fn};
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    @(negedge clk_i);
    items_sent++;
  endtask

  // Hold the sender until every owed result item has arrived
  task automatic wait_drain();
    s_axis_tvalid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk_i);
    @(negedge clk_i);
  endtask

  // Compare each accepted result item with the oldest prediction
  always @(posedge clk_i) begin
    result_t got;
    result_t want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      got = result_t'(m_axis_tdata[OUT_BITS-1:0]);
      results_seen++;
      if (pending_results.size() == 0) begin
        $display("%0t: unexpected result item, expected none, got 0x%0h", $time,
                 m_axis_tdata);
        error_count++;
      end else begin
        want = pending_results.pop_front();
        if (got.status != want.status) begin
          $display("%0t: status expected %0d got %0d", $time, want.status, got.status);
          error_count++;
        end
        if (got.found_level != want.found_level) begin
          $display("%0t: found_level expected %0d got %0d", $time, want.found_level,
                   got.found_level);
          error_count++;
        end
        if (got.entry_number != want.entry_number) begin
          $display("%0t: entry_number expected %0d got %0d", $time, want.entry_number,
                   got.entry_number);
          error_count++;
        end
        if (got.current_level != want.current_level) begin
          $display("%0t: current_level expected %0d got %0d", $time,
                   $signed(want.current_level), $signed(got.current_level));
          error_count++;
        end
      end
    end
  end

  // Close, insert and lookup with no scope open
  task automatic test_no_scope();
    send_item(FN_CLOSE, '0, '0);
    send_item(FN_INSERT, 64'h0000_0000_0000_0041, 4'd1);
    send_item(FN_LOOKUP, 64'h0000_0000_0000_0041, 4'd1);
  endtask

  // Insert, duplicate, shadowing and the three lookup outcomes
  task automatic test_insert_lookup();
    send_item(FN_OPEN, '0, '0);
    send_item(FN_INSERT, '0, 4'd0);
    send_item(FN_INSERT, '1, 4'd15);
    send_item(FN_INSERT, '0, 4'd5);
    send_item(FN_LOOKUP, '0, 4'd0);
    send_item(FN_LOOKUP, '1, 4'd15);
    send_item(FN_LOOKUP, '1, 4'd3);
    send_item(FN_LOOKUP, 64'h8000_0000_0000_0001, 4'd0);
    send_item(FN_OPEN, '0, '0);
    send_item(FN_INSERT, '1, 4'd7);
    // inner binding has another kind: no fall-through to the outer one
    send_item(FN_LOOKUP, '1, 4'd15);
    send_item(FN_LOOKUP, '1, 4'd7);
    send_item(FN_LOOKUP, '0, 4'd0);
    send_item(FN_CLOSE, '0, '0);
    send_item(FN_LOOKUP, '1, 4'd15);
    send_item(FN_CLOSE, '0, '0);
  endtask

  // Open to the deepest level, once more, then unwind past the outermost
  task automatic test_scope_depth();
    int i;
    for (i = 0; i <= int'(LEVELS); i++) send_item(FN_OPEN, '0, '0);
    send_item(FN_INSERT, 64'hA5A5_5A5A_0F0F_F0F0, 4'd9);
    send_item(FN_LOOKUP, 64'hA5A5_5A5A_0F0F_F0F0, 4'd9);
    for (i = 0; i <= int'(LEVELS); i++) send_item(FN_CLOSE, '0, '0);
  endtask

  // Fill every slot over a few levels, then hit the full and duplicate checks
  task automatic test_fill_table();
    logic [KEY_W-1:0] k;
    int               guard;
    guard = 0;
    k     = {$urandom, $urandom};
    send_item(FN_OPEN, '0, '0);
    while (stack_top < int'(ENTRIES) && guard < 4 * int'(ENTRIES)) begin
      if (stack_top % 20 == 19) send_item(FN_OPEN, '0, '0);
      k = {$urandom, $urandom};
      send_item(FN_INSERT, k, 4'($urandom));
      guard++;
    end
    send_item(FN_INSERT, {$urandom, $urandom}, 4'($urandom));
    send_item(FN_INSERT, k, 4'($urandom));
    send_item(FN_LOOKUP, k, sym_kind[ENTRIES-1]);
    send_item(FN_LOOKUP, sym_key[0], sym_kind[0]);
    while (cur_scope >= 0) send_item(FN_CLOSE, '0, '0);
  endtask

  // Mostly well-formed scoped traffic over a small key pool, some noise
  task automatic test_random_traffic(int unsigned count, int unsigned src_pct,
                                     int unsigned sink_pct);
    int unsigned      n;
    int unsigned      pick;
    int unsigned      slot;
    func_e            fn;
    logic [KEY_W-1:0] k;
    logic [KIND_W-1:0] kd;
    src_idle_pct  = src_pct;
    sink_idle_pct = sink_pct;
    for (n = 0; n < count; n++) begin
      if (n == count / 2) wait_drain();
      pick = $urandom_range(99);
      slot = $urandom_range(POOL_SIZE - 1);
      if ($urandom_range(49) == 0) key_pool[slot] = {$urandom, $urandom};
      k  = ($urandom_range(9) < 8) ? key_pool[slot] : {$urandom, $urandom};
      kd = ($urandom_range(3) != 0) ? kind_pool[slot] : 4'($urandom);
      if (pick < 5) begin
        fn = func_e'($urandom_range(3));
      end else if (cur_scope < 0 || pick < 18) begin
        fn = FN_OPEN;
      end else if (pick < 28) begin
        fn = FN_CLOSE;
      end else if (pick < 62) begin
        fn = FN_INSERT;
      end else begin
        fn = FN_LOOKUP;
      end
      send_item(fn, k, kd);
    end
  endtask

  // Test sequence
  initial begin
    int i;
    rst_ni    = 1'b0;
    stack_top = 0;
    cur_scope = -1;
    for (i = 0; i < 8; i++) status_count[i] = 0;
    for (i = 0; i < int'(POOL_SIZE); i++) begin
      key_pool[i]  = {$urandom, $urandom};
      kind_pool[i] = 4'($urandom);
    end
    key_pool[0] = '0;
    key_pool[1] = '1;
    key_pool[2] = 64'h8000_0000_0000_0000;
    key_pool[3] = 64'h0000_0000_0000_0001;
    key_pool[4] = 64'h5555_5555_5555_5555;
    key_pool[5] = 64'hAAAA_AAAA_AAAA_AAAA;
    repeat (4) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    test_no_scope();
    test_insert_lookup();
    test_scope_depth();
    wait_drain();
    test_fill_table();
    test_random_traffic(470, 17, 51);
    test_random_traffic(470, 51, 17);
    test_random_traffic(460, 0, 0);
    test_fill_table();

    // Let the last items drain, then watch for stray results
    wait_drain();
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    $display("Covered %0d items and %0d result items; deepest scope %0d.", items_sent,
             results_seen, deepest_scope);
    $display("Statuses: done %0d found %0d wrong-kind %0d missing %0d dup %0d",
             status_count[ST_DONE], status_count[ST_FOUND], status_count[ST_WRONG_TYPE],
             status_count[ST_NOT_FOUND], status_count[ST_DUPLICATE]);
    $display("  full %0d deep %0d none %0d", status_count[ST_FULL],
             status_count[ST_TOO_DEEP], status_count[ST_NO_SCOPE]);
    if (error_count == 0 && pending_results.size() == 0) begin
      $display("[scoped_symbol_table] OK");
    end else begin
      $display("[scoped_symbol_table] ERROR");
    end
    $finish;
  end

endmodule

// File: scoped_symbol_table.f
rtl/core/sst_pkg.sv
rtl/core/sst_entry_store.sv
rtl/core/sst_base_store.sv
rtl/core/sst_seq.sv
rtl/core/scoped_symbol_table.sv
rtl/core/sst_checker.sv
tb/sv/tb_top.sv
